// ----- hdl/atc_pkg.sv -----
// atc_pkg: shared types and constants for the ant tour construction block
// no dependencies; used by atc_weight_unit and ant_tour_construction_top
package atc_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD_DIST = 2'd0,
    MODE_LOAD_PHER = 2'd1,
    MODE_START     = 2'd2,
    MODE_HOP       = 2'd3
  } mode_t;

  localparam logic [1:0] CFG_ALPHA = 2'd0;
  localparam logic [1:0] CFG_BETA  = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_W_CAND, ST_W_MAT, ST_W_GO, ST_W_WAIT,
    ST_R_MUL, ST_R_RD, ST_R_ACC, ST_P_RD, ST_P_CITY, ST_P_EDGE,
    ST_P_CLOSE, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    WU_IDLE, WU_LOGP, WU_LOGD, WU_MULP, WU_MULD, WU_EXP
  } wu_state_t;

  typedef struct packed {
    logic        done;
    logic [31:0] weight;
  } wu_rsp_t;

  localparam logic signed [21:0] LOG_SIXTEEN  = 22'sd1048576;
  localparam logic signed [21:0] LOG_EIGHT    = 22'sd524288;
  localparam logic signed [28:0] EXP_BIAS     = 29'sd1048576;
  localparam logic signed [28:0] EXP_LIMIT    = 29'sd2097152;
  localparam logic [31:0]        WEIGHT_SAT   = 32'hFFFF_FFFF;

endpackage

// ----- hdl/atc_ram.sv -----
// atc_ram: single write port, single read port memory with registered read data
// no dependencies
module atc_ram #(
  parameter int AW    = 6,
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/atc_weight_unit.sv -----
// atc_weight_unit: pheromone^alpha * (1/distance)^beta through log2, multiply and exp2
// one shared log2 and one shared multiplier under a small sequencer; uses atc_pkg
module atc_weight_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [31:0]     pher,
  input  logic [31:0]     dist_in,
  input  logic [15:0]     alpha,
  input  logic [15:0]     beta,
  output atc_pkg::wu_rsp_t rsp
);

  atc_pkg::wu_state_t st_r, st_nxt;
  logic [31:0]        pher_r, pher_nxt;
  logic [31:0]        dist_r, dist_nxt;
  logic               pzero_r, pzero_nxt;
  logic signed [21:0] lp_r, lp_nxt;
  logic signed [21:0] ld_r, ld_nxt;
  logic signed [27:0] acc_r, acc_nxt;

  logic [31:0]        log_in;
  logic [4:0]         lead;
  logic [31:0]        norm;
  logic [20:0]        log_val;
  logic signed [21:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [38:0] prod;
  logic signed [26:0] term;
  logic signed [28:0] e_val;
  logic [47:0]        shifted;
  logic [31:0]        weight;

  // shared mitchell log2
  always_comb begin
    log_in = (st_r == atc_pkg::WU_LOGP) ? pher_r : dist_r;
    lead = 5'd0;
    for (int k = 0; k < 32; k++) begin
      if (log_in[k]) lead = 5'(k);
    end
    norm    = log_in << (5'd31 - lead);
    log_val = {lead, norm[30:15]};
  end

  // shared multiplier
  always_comb begin
    mul_a = (st_r == atc_pkg::WU_MULP) ? lp_r : ld_r;
    mul_b = (st_r == atc_pkg::WU_MULP) ? alpha : beta;
    prod  = 39'(mul_a) * $signed({23'd0, mul_b});
    term  = $signed(prod[38:12]);
  end

  // exp2 with saturation
  always_comb begin
    e_val   = 29'(acc_r) + atc_pkg::EXP_BIAS;
    shifted = 48'({1'b1, e_val[15:0]}) << e_val[20:16];
    if (pzero_r && (alpha != 16'd0)) begin
      weight = 32'd0;
    end else if (e_val < 0) begin
      weight = 32'd0;
    end else if (e_val >= atc_pkg::EXP_LIMIT) begin
      weight = atc_pkg::WEIGHT_SAT;
    end else begin
      weight = shifted[47:16];
    end
  end

  always_comb begin
    st_nxt    = st_r;
    pher_nxt  = pher_r;
    dist_nxt  = dist_r;
    pzero_nxt = pzero_r;
    lp_nxt    = lp_r;
    ld_nxt    = ld_r;
    acc_nxt   = acc_r;
    unique case (st_r)
      atc_pkg::WU_IDLE: begin
        if (start) begin
          pher_nxt  = pher;
          dist_nxt  = (dist_in == 32'd0) ? 32'd1 : dist_in;
          pzero_nxt = (pher == 32'd0);
          st_nxt    = atc_pkg::WU_LOGP;
        end
      end
      atc_pkg::WU_LOGP: begin
        lp_nxt = $signed({1'b0, log_val}) - atc_pkg::LOG_SIXTEEN;
        st_nxt = atc_pkg::WU_LOGD;
      end
      atc_pkg::WU_LOGD: begin
        ld_nxt = atc_pkg::LOG_EIGHT - $signed({1'b0, log_val});
        st_nxt = atc_pkg::WU_MULP;
      end
      atc_pkg::WU_MULP: begin
        acc_nxt = pzero_r ? 28'sd0 : 28'(term);
        st_nxt  = atc_pkg::WU_MULD;
      end
      atc_pkg::WU_MULD: begin
        acc_nxt = acc_r + 28'(term);
        st_nxt  = atc_pkg::WU_EXP;
      end
      atc_pkg::WU_EXP: begin
        st_nxt = atc_pkg::WU_IDLE;
      end
      default: st_nxt = atc_pkg::WU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= atc_pkg::WU_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    pher_r  <= pher_nxt;
    dist_r  <= dist_nxt;
    pzero_r <= pzero_nxt;
    lp_r    <= lp_nxt;
    ld_r    <= ld_nxt;
    acc_r   <= acc_nxt;
  end

  assign rsp.done   = (st_r == atc_pkg::WU_EXP);
  assign rsp.weight = weight;

endmodule

// ----- hdl/ant_tour_construction_top.sv -----
// ant_tour_construction_top: ant colony tour construction with roulette city selection
// uses atc_pkg, atc_ram (matrices, candidate list, weights) and atc_weight_unit
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid/in_stall, mode and fields      | in
//  result  | out_valid/out_stall, city and distances | out
//  config  | cfg_we, cfg_index, cfg_data             | in
//
// load transactions are written on accept; a start with n clamped cities fills the candidate
// list with the n-1 cities other than the start city in one sweep after accept
// a hop runs each of its r candidates through the shared weight unit, then steps the roulette
// through weight ram up to the picked candidate (skipped when all weights are zero), and the
// closing hop adds the return edge to the origin
// rst_n is synchronous; matrices and lists are undefined until written, no clearing pass
// a pending result is held in the output register; only hop transactions wait on it
module ant_tour_construction_top #(
  parameter int MAX_CITIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_row_city,
  input  logic [5:0]  in_column_city,
  input  logic [31:0] in_entry_value,
  input  logic [5:0]  in_start_city,
  input  logic [15:0] in_random_fraction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_chosen_city,
  output logic [31:0] out_edge_distance,
  output logic [37:0] out_total_distance,
  output logic        out_tour_done,
  output logic        out_hop_error,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(MAX_CITIES);
  localparam int AW = 2 * CW;
  localparam int NW = $clog2(MAX_CITIES + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  atc_pkg::state_t state_r, state_nxt;
  atc_pkg::mode_t  mode;

  logic [15:0]   alpha_r, beta_r;
  logic [6:0]    count_r;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] origin_r, origin_nxt;
  logic [37:0]   run_r, run_nxt;
  logic          active_r, active_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pick_r, pick_nxt;
  logic [CW-1:0] city_r, city_nxt;
  logic [31:0]   edge_r, edge_nxt;
  logic [37:0]   wtot_r, wtot_nxt;
  logic [37:0]   cum_r, cum_nxt;
  logic [53:0]   target_r, target_nxt;
  logic [15:0]   rnd_r, rnd_nxt;
  logic          done_r, done_nxt;

  logic          ov_r, ov_nxt;
  logic [5:0]    oc_r, oc_nxt;
  logic [31:0]   oe_r, oe_nxt;
  logic [37:0]   ot_r, ot_nxt;
  logic          od_r, od_nxt;
  logic          oerr_r, oerr_nxt;

  logic          acc_in, out_free, load_ok, idx_last;
  logic [XW-1:0] row_x, col_x, start_x, city_x;
  logic [NW-1:0] n_clamp;
  logic [37:0]   cum_sum;

  logic          dist_we, pher_we, cand_we, wt_we, wu_start;
  logic [AW-1:0] mat_waddr, dist_raddr, pher_raddr;
  logic [31:0]   dist_q, pher_q, wt_q;
  logic [CW-1:0] cand_waddr, cand_wdata, cand_raddr, cand_q, wt_raddr;
  atc_pkg::wu_rsp_t wu_rsp;

  assign mode     = atc_pkg::mode_t'(in_mode);
  assign in_stall = (state_r != atc_pkg::ST_IDLE) || (ov_r && (mode == atc_pkg::MODE_HOP));
  assign acc_in   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;

  assign row_x     = XW'(in_row_city);
  assign col_x     = XW'(in_column_city);
  assign start_x   = XW'(in_start_city);
  assign city_x    = XW'(city_r);
  assign load_ok   = (32'(in_row_city) < MAX_CITIES) && (32'(in_column_city) < MAX_CITIES);
  assign mat_waddr = {row_x[CW-1:0], col_x[CW-1:0]};
  assign idx_last  = (NW'(idx_r) == rem_r - NW'(1));
  assign cum_sum   = cum_r + 38'(wt_q);

  always_comb begin
    if (count_r < 7'd2) begin
      n_clamp = NW'(2);
    end else if (32'(count_r) > MAX_CITIES) begin
      n_clamp = NW'(MAX_CITIES);
    end else begin
      n_clamp = NW'(count_r);
    end
  end

  assign dist_we = acc_in && (mode == atc_pkg::MODE_LOAD_DIST) && load_ok;
  assign pher_we = acc_in && (mode == atc_pkg::MODE_LOAD_PHER) && load_ok;

  always_comb begin
    state_nxt  = state_r;
    rem_nxt    = rem_r;
    cur_nxt    = cur_r;
    origin_nxt = origin_r;
    run_nxt    = run_r;
    active_nxt = active_r;
    idx_nxt    = idx_r;
    pick_nxt   = pick_r;
    city_nxt   = city_r;
    edge_nxt   = edge_r;
    wtot_nxt   = wtot_r;
    cum_nxt    = cum_r;
    target_nxt = target_r;
    rnd_nxt    = rnd_r;
    done_nxt   = done_r;
    ov_nxt     = ov_r && out_stall;
    oc_nxt     = oc_r;
    oe_nxt     = oe_r;
    ot_nxt     = ot_r;
    od_nxt     = od_r;
    oerr_nxt   = oerr_r;
    cand_we    = 1'b0;
    cand_waddr = idx_r;
    cand_wdata = idx_r;
    cand_raddr = idx_r;
    wt_we      = 1'b0;
    wt_raddr   = idx_r;
    wu_start   = 1'b0;
    dist_raddr = {cur_r, cand_q};
    pher_raddr = {cur_r, cand_q};
    unique case (state_r)
      atc_pkg::ST_IDLE: begin
        if (acc_in) begin
          unique case (mode)
            atc_pkg::MODE_START: begin
              if (32'(in_start_city) < 32'(n_clamp)) begin
                rem_nxt    = n_clamp - NW'(1);
                cur_nxt    = start_x[CW-1:0];
                origin_nxt = start_x[CW-1:0];
                run_nxt    = 38'd0;
                active_nxt = 1'b1;
                idx_nxt    = '0;
                state_nxt  = atc_pkg::ST_INIT;
              end
            end
            atc_pkg::MODE_HOP: begin
              if (active_r && (rem_r != '0)) begin
                idx_nxt   = '0;
                wtot_nxt  = 38'd0;
                rnd_nxt   = in_random_fraction;
                done_nxt  = 1'b0;
                state_nxt = atc_pkg::ST_W_CAND;
              end else begin
                ov_nxt   = 1'b1;
                oc_nxt   = 6'd0;
                oe_nxt   = 32'd0;
                ot_nxt   = 38'd0;
                od_nxt   = 1'b0;
                oerr_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      atc_pkg::ST_INIT: begin
        cand_we    = 1'b1;
        cand_wdata = (idx_r == origin_r) ? rem_r[CW-1:0] : idx_r;
        if (idx_last) begin
          state_nxt = atc_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      atc_pkg::ST_W_CAND: state_nxt = atc_pkg::ST_W_MAT;
      atc_pkg::ST_W_MAT:  state_nxt = atc_pkg::ST_W_GO;
      atc_pkg::ST_W_GO: begin
        wu_start  = 1'b1;
        state_nxt = atc_pkg::ST_W_WAIT;
      end
      atc_pkg::ST_W_WAIT: begin
        if (wu_rsp.done) begin
          wt_we    = 1'b1;
          wtot_nxt = wtot_r + 38'(wu_rsp.weight);
          if (idx_last) begin
            idx_nxt   = '0;
            cum_nxt   = 38'd0;
            state_nxt = atc_pkg::ST_R_MUL;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = atc_pkg::ST_W_CAND;
          end
        end
      end
      atc_pkg::ST_R_MUL: begin
        if (wtot_r == 38'd0) begin
          pick_nxt  = CW'(rem_r - NW'(1));
          state_nxt = atc_pkg::ST_P_RD;
        end else begin
          target_nxt = 54'(rnd_r) * 54'(wtot_r);
          state_nxt  = atc_pkg::ST_R_RD;
        end
      end
      atc_pkg::ST_R_RD: state_nxt = atc_pkg::ST_R_ACC;
      atc_pkg::ST_R_ACC: begin
        cum_nxt = cum_sum;
        if (({cum_sum, 16'd0} >= target_r) || idx_last) begin
          pick_nxt  = idx_r;
          state_nxt = atc_pkg::ST_P_RD;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = atc_pkg::ST_R_RD;
        end
      end
      atc_pkg::ST_P_RD: begin
        cand_raddr = pick_r;
        state_nxt  = atc_pkg::ST_P_CITY;
      end
      atc_pkg::ST_P_CITY: begin
        city_nxt   = cand_q;
        cand_raddr = CW'(rem_r - NW'(1));
        state_nxt  = atc_pkg::ST_P_EDGE;
      end
      atc_pkg::ST_P_EDGE: begin
        edge_nxt   = dist_q;
        cand_we    = 1'b1;
        cand_waddr = pick_r;
        cand_wdata = cand_q;
        run_nxt    = run_r + 38'(dist_q);
        rem_nxt    = rem_r - NW'(1);
        cur_nxt    = city_r;
        dist_raddr = {city_r, origin_r};
        state_nxt  = (rem_r == NW'(1)) ? atc_pkg::ST_P_CLOSE : atc_pkg::ST_FIN;
      end
      atc_pkg::ST_P_CLOSE: begin
        run_nxt    = run_r + 38'(dist_q);
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
        state_nxt  = atc_pkg::ST_FIN;
      end
      atc_pkg::ST_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oc_nxt    = city_x[5:0];
          oe_nxt    = edge_r;
          ot_nxt    = run_r;
          od_nxt    = done_r;
          oerr_nxt  = 1'b0;
          state_nxt = atc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = atc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= atc_pkg::ST_IDLE;
      alpha_r  <= 16'd4096;
      beta_r   <= 16'd8192;
      count_r  <= 7'd64;
      rem_r    <= '0;
      cur_r    <= '0;
      origin_r <= '0;
      run_r    <= 38'd0;
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rem_r    <= rem_nxt;
      cur_r    <= cur_nxt;
      origin_r <= origin_nxt;
      run_r    <= run_nxt;
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          atc_pkg::CFG_ALPHA: alpha_r <= cfg_data;
          atc_pkg::CFG_BETA:  beta_r  <= cfg_data;
          atc_pkg::CFG_COUNT: count_r <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
    idx_r    <= idx_nxt;
    pick_r   <= pick_nxt;
    city_r   <= city_nxt;
    edge_r   <= edge_nxt;
    wtot_r   <= wtot_nxt;
    cum_r    <= cum_nxt;
    target_r <= target_nxt;
    rnd_r    <= rnd_nxt;
    done_r   <= done_nxt;
    oc_r     <= oc_nxt;
    oe_r     <= oe_nxt;
    ot_r     <= ot_nxt;
    od_r     <= od_nxt;
    oerr_r   <= oerr_nxt;
  end

  atc_ram #(.AW(AW), .WIDTH(32)) u_dist_ram (
    .clk(clk), .we(dist_we), .waddr(mat_waddr), .wdata(in_entry_value),
    .raddr(dist_raddr), .rdata(dist_q)
  );

  atc_ram #(.AW(AW), .WIDTH(32)) u_pher_ram (
    .clk(clk), .we(pher_we), .waddr(mat_waddr), .wdata(in_entry_value),
    .raddr(pher_raddr), .rdata(pher_q)
  );

  atc_ram #(.AW(CW), .WIDTH(CW)) u_cand_ram (
    .clk(clk), .we(cand_we), .waddr(cand_waddr), .wdata(cand_wdata),
    .raddr(cand_raddr), .rdata(cand_q)
  );

  atc_ram #(.AW(CW), .WIDTH(32)) u_wt_ram (
    .clk(clk), .we(wt_we), .waddr(idx_r), .wdata(wu_rsp.weight),
    .raddr(wt_raddr), .rdata(wt_q)
  );

  atc_weight_unit u_weight (
    .clk(clk), .rst_n(rst_n), .start(wu_start), .pher(pher_q), .dist_in(dist_q),
    .alpha(alpha_r), .beta(beta_r), .rsp(wu_rsp)
  );

  assign out_valid          = ov_r;
  assign out_chosen_city    = oc_r;
  assign out_edge_distance  = oe_r;
  assign out_total_distance = ot_r;
  assign out_tour_done      = od_r;
  assign out_hop_error      = oerr_r;

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != atc_pkg::ST_IDLE) |-> in_stall)
    else $error("input taken while a transaction is in progress");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= NW'(MAX_CITIES - 1))
    else $error("remaining count out of range");

  a_done_ends_tour: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(ov_r) && od_r) |-> !active_r)
    else $error("tour done reported while tour still active");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oerr_r) |-> (oc_r == 6'd0 && ot_r == 38'd0 && !od_r))
    else $error("hop error result carries data");

endmodule

// ----- dv/atc_tour_checker.sv -----
`timescale 1ns / 1ps
// atc_tour_checker: watches the input, result and config ports of the ant tour block,
// predicts every hop result and compares it field by field; uses atc_pkg
module atc_tour_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_row_city,
  input  logic [5:0]  in_column_city,
  input  logic [31:0] in_entry_value,
  input  logic [5:0]  in_start_city,
  input  logic [15:0] in_random_fraction,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  out_chosen_city,
  input  logic [31:0] out_edge_distance,
  input  logic [37:0] out_total_distance,
  input  logic        out_tour_done,
  input  logic        out_hop_error,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          hops_pending
);

  localparam int NCITY = 64;
  localparam longint Q16_EIGHT   = 524288;
  localparam longint Q16_SIXTEEN = 1048576;
  localparam longint Q16_TOP     = 2097152;

  typedef struct packed {
    logic [5:0]  city;
    logic [31:0] edge_len;
    logic [37:0] total;
    logic        done;
    logic        err;
  } hop_result_t;

  hop_result_t hop_queue[$];

  logic [15:0] alpha_q;
  logic [15:0] beta_q;
  logic [6:0]  count_q;
  logic [31:0] dist_tab [NCITY*NCITY];
  logic [31:0] pher_tab [NCITY*NCITY];
  logic [5:0]  cand [NCITY];
  logic [31:0] wgt [NCITY];
  int          remain;
  logic [5:0]  cur_city;
  logic [5:0]  origin;
  logic [37:0] run_total;
  logic        active;

  assign hops_pending = hop_queue.size();

  function automatic longint log2_q16(logic [31:0] x);
    int e;
    longint rem;
    e = 31;
    while (e > 0 && !x[e]) e--;
    rem = longint'(x) - (longint'(1) << e);
    if (e >= 16) rem = rem >> (e - 16);
    else rem = rem << (16 - e);
    return (longint'(e) << 16) + rem;
  endfunction

  function automatic longint scale_exp(longint l, logic [15:0] ex);
    longint p;
    p = l * longint'(ex);
    if (p >= 0) return p >>> 12;
    return -(((-p) + 4095) >>> 12);
  endfunction

  function automatic logic [31:0] city_weight(logic [31:0] ph, logic [31:0] d);
    longint s;
    longint e;
    longint mant;
    s = 0;
    if (ph == 0) begin
      if (alpha_q != 0) return 32'd0;
    end else begin
      s += scale_exp(log2_q16(ph) - Q16_SIXTEEN, alpha_q);
    end
    if (d == 0) d = 32'd1;
    s += scale_exp(Q16_EIGHT - log2_q16(d), beta_q);
    e = s + Q16_SIXTEEN;
    if (e < 0) return 32'd0;
    if (e >= Q16_TOP) return 32'hFFFF_FFFF;
    mant = 65536 + (e & 65535);
    return 32'((mant << (e >> 16)) >> 16);
  endfunction

  task automatic predict_hop(input logic [15:0] frac);
    hop_result_t r;
    longint unsigned total;
    longint unsigned cum;
    longint unsigned target;
    int pick;
    logic [5:0] c;
    r = '0;
    if (!active || remain == 0) begin
      r.err = 1'b1;
    end else begin
      total = 0;
      cum = 0;
      pick = remain - 1;
      for (int i = 0; i < remain; i++) begin
        c = cand[i];
        wgt[c] = city_weight(pher_tab[{cur_city, c}], dist_tab[{cur_city, c}]);
        total += wgt[c];
      end
      if (total != 0) begin
        target = longint'(frac) * total;
        for (int i = 0; i < remain; i++) begin
          cum += wgt[cand[i]];
          if ((cum << 16) >= target) begin
            pick = i;
            break;
          end
        end
      end
      c = cand[pick];
      r.edge_len = dist_tab[{cur_city, c}];
      run_total = run_total + r.edge_len;
      cand[pick] = cand[remain-1];
      remain--;
      cur_city = c;
      if (remain == 0) begin
        run_total = run_total + dist_tab[{c, origin}];
        active = 1'b0;
        r.done = 1'b1;
      end
      r.city = c;
      r.total = run_total;
    end
    hop_queue.push_back(r);
  endtask

  task automatic apply_transaction();
    int n;
    case (atc_pkg::mode_t'(in_mode))
      atc_pkg::MODE_LOAD_DIST: dist_tab[{in_row_city, in_column_city}] = in_entry_value;
      atc_pkg::MODE_LOAD_PHER: pher_tab[{in_row_city, in_column_city}] = in_entry_value;
      atc_pkg::MODE_START: begin
        n = count_q;
        if (n < 2) n = 2;
        if (n > NCITY) n = NCITY;
        if (in_start_city < n) begin
          for (int i = 0; i < n; i++) cand[i] = 6'(i);
          cand[in_start_city] = cand[n-1];
          remain = n - 1;
          cur_city = in_start_city;
          origin = in_start_city;
          run_total = '0;
          active = 1'b1;
        end
      end
      default: predict_hop(in_random_fraction);
    endcase
  endtask

  task automatic flag(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  initial mismatch_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      alpha_q = 16'd4096;
      beta_q = 16'd8192;
      count_q = 7'd64;
      remain = 0;
      cur_city = '0;
      origin = '0;
      run_total = '0;
      active = 1'b0;
      hop_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (hop_queue.size() == 0) begin
          mismatch_count++;
          $display("%0t: result city %0h with no transaction pending", $time, out_chosen_city);
        end else begin
          flag("chosen_city", hop_queue[0].city, out_chosen_city);
          flag("edge_distance", hop_queue[0].edge_len, out_edge_distance);
          flag("total_distance", hop_queue[0].total, out_total_distance);
          flag("tour_done", hop_queue[0].done, out_tour_done);
          flag("hop_error", hop_queue[0].err, out_hop_error);
          void'(hop_queue.pop_front());
        end
      end
      if (in_valid && !in_stall) apply_transaction();
      if (cfg_we) begin
        case (cfg_index)
          atc_pkg::CFG_ALPHA: alpha_q = cfg_data;
          atc_pkg::CFG_BETA:  beta_q = cfg_data;
          atc_pkg::CFG_COUNT: count_q = cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- dv/tb_ant_tour_construction_top.sv -----
`timescale 1ns / 1ps
// tb_ant_tour_construction_top: stimulus and verdict for ant_tour_construction_top
// fills the used corner of both matrices, runs directed and random tours; checking in atc_tour_checker
module tb_ant_tour_construction_top;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int FILL = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = atc_pkg::MODE_LOAD_DIST;
  logic [5:0]  in_row_city = '0;
  logic [5:0]  in_column_city = '0;
  logic [31:0] in_entry_value = '0;
  logic [5:0]  in_start_city = '0;
  logic [15:0] in_random_fraction = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_chosen_city;
  logic [31:0] out_edge_distance;
  logic [37:0] out_total_distance;
  logic        out_tour_done;
  logic        out_hop_error;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = atc_pkg::CFG_ALPHA;
  logic [15:0] cfg_data = '0;

  int mismatch_count;
  int hops_pending;
  int cycle_count = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 0;
  bit calm = 0;
  int cities_now = 64;
  int hops_left = 0;

  ant_tour_construction_top uut (.*);

  atc_tour_checker u_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) results_seen++;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && results_seen >= 300) begin
        hold_done = 1;
        hold_left = 500;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 19);
      end
    end
  end

  function automatic logic [31:0] rand_mag();
    return $urandom >> $urandom_range(31);
  endfunction

  task automatic send(atc_pkg::mode_t m, logic [5:0] r, logic [5:0] c, logic [31:0] v,
                      logic [5:0] s, logic [15:0] f);
    if (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_row_city <= r;
    in_column_city <= c;
    in_entry_value <= v;
    in_start_city <= s;
    in_random_fraction <= f;
    do @(posedge clk); while (in_stall);
    if (m == atc_pkg::MODE_START && s < cities_now) hops_left = cities_now - 1;
    else if (m == atc_pkg::MODE_HOP && hops_left > 0) hops_left--;
  endtask

  task automatic hop(logic [15:0] f);
    send(atc_pkg::MODE_HOP, 6'($urandom), 6'($urandom), $urandom, 6'($urandom), f);
  endtask

  task automatic start_tour(logic [5:0] s);
    send(atc_pkg::MODE_START, 6'($urandom), 6'($urandom), $urandom, s, 16'($urandom));
  endtask

  task automatic load(atc_pkg::mode_t m, logic [5:0] r, logic [5:0] c, logic [31:0] v);
    send(m, r, c, v, 6'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (hops_pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == atc_pkg::CFG_COUNT) begin
      cities_now = d[6:0];
      if (cities_now < 2) cities_now = 2;
      if (cities_now > 64) cities_now = 64;
    end
  endtask

  initial begin
    int counts [10] = '{2, 5, 20, 8, 3, 17, 12, 6, 1, 19};
    int alphas [10] = '{4096, 0, 65535, 2048, 12288, 4096, 1000, 65535, 8192, 3000};
    int betas  [10] = '{8192, 65535, 0, 4096, 16384, 2000, 0, 65535, 4096, 12000};
    int sent;
    int pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < FILL; r++) begin
      for (int c = 0; c < FILL; c++) begin
        load(atc_pkg::MODE_LOAD_DIST, 6'(r), 6'(c), rand_mag());
        load(atc_pkg::MODE_LOAD_PHER, 6'(r), 6'(c), rand_mag());
      end
    end

    // directed: stray hop, clamps, zero weights, zero pheromone, zero distance, extremes
    hop(16'h1234);
    drain();
    write_reg(atc_pkg::CFG_COUNT, 16'd0);
    start_tour(6'd1);
    start_tour(6'd5);
    hop(16'd0);
    load(atc_pkg::MODE_LOAD_PHER, 6'd0, 6'd1, 32'd0);
    load(atc_pkg::MODE_LOAD_PHER, 6'd0, 6'd2, 32'd0);
    drain();
    write_reg(atc_pkg::CFG_COUNT, 16'd3);
    start_tour(6'd0);
    hop(16'hFFFF);
    hop(16'd0);
    drain();
    write_reg(atc_pkg::CFG_ALPHA, 16'd0);
    start_tour(6'd0);
    hop(16'h8000);
    hop(16'h4000);
    load(atc_pkg::MODE_LOAD_DIST, 6'd1, 6'd2, 32'd0);
    load(atc_pkg::MODE_LOAD_DIST, 6'd0, 6'd1, 32'hFFFF_FFFF);
    load(atc_pkg::MODE_LOAD_PHER, 6'd0, 6'd1, 32'hFFFF_FFFF);
    drain();
    write_reg(atc_pkg::CFG_ALPHA, 16'hFFFF);
    write_reg(atc_pkg::CFG_BETA, 16'hFFFF);
    start_tour(6'd0);
    hop(16'd0);
    start_tour(6'd1);
    hop(16'hFFFF);
    hop(16'hFFFF);
    hop(16'h0001);

    for (int p = 0; p < 10; p++) begin
      drain();
      calm = (p == 3);
      write_reg(atc_pkg::CFG_ALPHA, 16'(alphas[p]));
      write_reg(atc_pkg::CFG_BETA, 16'(betas[p]));
      write_reg(atc_pkg::CFG_COUNT, 16'(counts[p]));
      sent = 0;
      while (sent < 100) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          load(($urandom_range(1) != 0) ? atc_pkg::MODE_LOAD_PHER : atc_pkg::MODE_LOAD_DIST,
               6'($urandom), 6'($urandom),
               ($urandom_range(9) == 0) ? 32'd0 : rand_mag());
        end else if (pick < 11) begin
          hop(16'($urandom));
        end else if (pick < 14) begin
          start_tour(6'($urandom));
        end else if (hops_left == 0) begin
          start_tour(6'($urandom_range(cities_now - 1)));
        end else begin
          hop(16'($urandom));
        end
        sent++;
      end
    end
    calm = 0;

    drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
